// ===== hdl/fdr_pkg.sv =====
`default_nettype none
package fdr_pkg;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned BYTES_W = 4;
  localparam int unsigned LEN_W   = 14;
  localparam int unsigned IFC_W   = 16;
  localparam int unsigned ROUTE_W = 2;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CIDX_W  = 2;

  localparam logic KIND_BEAT = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [ROUTE_W-1:0] ROUTE_PASS    = 2'd0;
  localparam logic [ROUTE_W-1:0] ROUTE_EGRESS  = 2'd1;
  localparam logic [ROUTE_W-1:0] ROUTE_INGRESS = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_DELAY   = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_TARGET  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_INGRESS = 2'd2;

  typedef enum logic [2:0] {
    MODE_PASS     = 3'b001,
    MODE_CAPTURE  = 3'b010,
    MODE_REDIRECT = 3'b100
  } fdr_mode_t;

  typedef struct packed {
    logic               kind;
    logic [DATA_W-1:0]  beat_data;
    logic [BYTES_W-1:0] beat_bytes;
    logic               beat_last;
    logic [LEN_W-1:0]   frame_length;
  } fdr_in_t;

  typedef struct packed {
    logic [DATA_W-1:0]  out_data;
    logic [BYTES_W-1:0] out_bytes;
    logic               out_last;
    logic [ROUTE_W-1:0] route;
    logic [IFC_W-1:0]   out_interface;
  } fdr_out_t;

endpackage
`default_nettype wire

// ===== hdl/frame_delay_reorder.sv =====
// Delays one frame of a beat stream. A write of delay_frames arms the block: the first
// frame of exactly FRAME_BYTES bytes is stored and dropped, later frames pass and count
// down, and once the count is zero the next frame goes to the target interface; replay
// ticks then send the stored frame out there, one beat per tick. One item is accepted
// per clock, and each result appears in the cycle after its item, in an output register;
// a stalled result holds the input off, and the next item enters in the cycle that the
// waiting result is taken. The stored frame sits in a single memory
// of ceil(FRAME_BYTES/8) 64-bit words with one write port for capture and one read port
// for replay; its registered read data drives the output beat through a select.
// No clearing pass runs after reset: replay words beyond what the last capture wrote
// read as zero.
`default_nettype none
module frame_delay_reorder #(
  parameter int unsigned FRAME_BYTES = 1514
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire fdr_pkg::fdr_in_t                in_beat,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output fdr_pkg::fdr_out_t                    out_beat,
  input  wire logic                            cfg_we,
  input  wire logic [fdr_pkg::CIDX_W-1:0]      cfg_index,
  input  wire logic [fdr_pkg::CFG_W-1:0]       cfg_wdata
);
  import fdr_pkg::*;

  localparam int unsigned SAVE_DEPTH = (FRAME_BYTES + 7) / 8;
  localparam int unsigned LAST_BYTES = FRAME_BYTES - 8 * (SAVE_DEPTH - 1);
  localparam int unsigned IW = (SAVE_DEPTH > 1) ? $clog2(SAVE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(SAVE_DEPTH + 1);
  localparam logic [LEN_W-1:0]   FRAME_LEN  = LEN_W'(FRAME_BYTES);
  localparam logic [CW-1:0]      DEPTH_C    = CW'(SAVE_DEPTH);
  localparam logic [IW-1:0]      LAST_IDX   = IW'(SAVE_DEPTH - 1);
  localparam logic [BYTES_W-1:0] LAST_BYTES_C = BYTES_W'(LAST_BYTES);
  localparam logic [BYTES_W-1:0] FULL_BYTES = BYTES_W'(8);

  logic [DATA_W-1:0] mem [SAVE_DEPTH];

  logic                  frame_saved_r, frame_saved_nxt;
  logic [CFG_W-1:0]      countdown_r, countdown_nxt;
  fdr_mode_t             frame_mode_r, frame_mode_nxt;
  logic                  in_frame_r, in_frame_nxt;
  logic [CW-1:0]         write_index_r, write_index_nxt;
  logic                  replay_pending_r, replay_pending_nxt;
  logic [IW-1:0]         replay_index_r, replay_index_nxt;
  logic [IFC_W-1:0]      target_r, target_nxt;
  logic                  ingress_r, ingress_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [DATA_W-1:0]     data_r, data_nxt;
  logic [BYTES_W-1:0]    bytes_r, bytes_nxt;
  logic                  last_r, last_nxt;
  logic [ROUTE_W-1:0]    route_r, route_nxt;
  logic [IFC_W-1:0]      ifc_r, ifc_nxt;
  logic                  sel_mem_r, sel_mem_nxt;
  logic [DATA_W-1:0]     rd_data_r;

  logic                  in_fire;
  logic                  res_valid;
  logic                  len_match;
  logic                  cnt_dec;
  fdr_mode_t             mode_cur;
  logic [CW-1:0]         wi;
  logic                  mem_we;
  logic [DATA_W-1:0]     mem_wdata;
  logic                  rd_en;
  logic [ROUTE_W-1:0]    redir_route;
  logic                  fin;

  assign in_ready    = !out_valid_r || out_ready;
  assign in_fire     = in_valid && in_ready;
  assign len_match   = in_beat.frame_length == FRAME_LEN;
  assign redir_route = ingress_r ? ROUTE_INGRESS : ROUTE_EGRESS;
  assign fin         = replay_index_r == LAST_IDX;
  assign wi          = in_frame_r ? write_index_r : '0;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mem_wdata[8*b +: 8] = (BYTES_W'(b) < in_beat.beat_bytes) ? in_beat.beat_data[8*b +: 8]
                                                              : 8'd0;
    end
  end

  always_comb begin
    mode_cur = frame_mode_r;
    cnt_dec  = 1'b0;
    if (!in_frame_r) begin
      mode_cur = MODE_PASS;
      if (!replay_pending_r) begin
        if (countdown_r != '0) begin
          if (frame_saved_r) begin
            cnt_dec = 1'b1;
          end else if (len_match) begin
            mode_cur = MODE_CAPTURE;
            cnt_dec  = 1'b1;
          end
        end else if (frame_saved_r) begin
          mode_cur = MODE_REDIRECT;
        end
      end
    end
  end

  always_comb begin
    frame_saved_nxt    = frame_saved_r;
    countdown_nxt      = countdown_r;
    frame_mode_nxt     = frame_mode_r;
    in_frame_nxt       = in_frame_r;
    write_index_nxt    = write_index_r;
    replay_pending_nxt = replay_pending_r;
    replay_index_nxt   = replay_index_r;
    target_nxt         = target_r;
    ingress_nxt        = ingress_r;
    out_valid_nxt      = out_valid_r;
    data_nxt           = data_r;
    bytes_nxt          = bytes_r;
    last_nxt           = last_r;
    route_nxt          = route_r;
    ifc_nxt            = ifc_r;
    sel_mem_nxt        = sel_mem_r;
    res_valid          = 1'b0;
    mem_we             = 1'b0;
    rd_en              = 1'b0;

    if (in_fire) begin
      if (in_beat.kind == KIND_TICK) begin
        if (replay_pending_r) begin
          res_valid   = 1'b1;
          rd_en       = CW'(replay_index_r) < write_index_r;
          sel_mem_nxt = rd_en;
          data_nxt    = '0;
          bytes_nxt   = fin ? LAST_BYTES_C : FULL_BYTES;
          last_nxt    = fin;
          route_nxt   = redir_route;
          ifc_nxt     = target_r;
          if (fin) begin
            replay_pending_nxt = 1'b0;
            replay_index_nxt   = '0;
          end else begin
            replay_index_nxt = replay_index_r + 1'b1;
          end
        end
      end else begin
        frame_mode_nxt = mode_cur;
        in_frame_nxt   = !in_beat.beat_last;
        if (cnt_dec) begin
          countdown_nxt = countdown_r - 1'b1;
        end
        case (mode_cur)
          MODE_CAPTURE: begin
            frame_saved_nxt = 1'b1;
            write_index_nxt = wi;
            if (wi < DEPTH_C) begin
              mem_we          = 1'b1;
              write_index_nxt = wi + 1'b1;
            end
          end
          MODE_REDIRECT: begin
            res_valid   = 1'b1;
            sel_mem_nxt = 1'b0;
            data_nxt    = in_beat.beat_data;
            bytes_nxt   = in_beat.beat_bytes;
            last_nxt    = in_beat.beat_last;
            route_nxt   = redir_route;
            ifc_nxt     = target_r;
            if (in_beat.beat_last) begin
              frame_saved_nxt    = 1'b0;
              replay_pending_nxt = 1'b1;
              replay_index_nxt   = '0;
            end
          end
          default: begin
            res_valid   = 1'b1;
            sel_mem_nxt = 1'b0;
            data_nxt    = in_beat.beat_data;
            bytes_nxt   = in_beat.beat_bytes;
            last_nxt    = in_beat.beat_last;
            route_nxt   = ROUTE_PASS;
            ifc_nxt     = '0;
          end
        endcase
      end
    end

    if (in_ready) begin
      out_valid_nxt = res_valid;
    end

    if (cfg_we) begin
      case (cfg_index)
        CFG_DELAY:   countdown_nxt = cfg_wdata;
        CFG_TARGET:  target_nxt    = cfg_wdata;
        CFG_INGRESS: ingress_nxt   = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_saved_r    <= 1'b0;
      countdown_r      <= '0;
      frame_mode_r     <= MODE_PASS;
      in_frame_r       <= 1'b0;
      write_index_r    <= '0;
      replay_pending_r <= 1'b0;
      replay_index_r   <= '0;
      target_r         <= '0;
      ingress_r        <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      frame_saved_r    <= frame_saved_nxt;
      countdown_r      <= countdown_nxt;
      frame_mode_r     <= frame_mode_nxt;
      in_frame_r       <= in_frame_nxt;
      write_index_r    <= write_index_nxt;
      replay_pending_r <= replay_pending_nxt;
      replay_index_r   <= replay_index_nxt;
      target_r         <= target_nxt;
      ingress_r        <= ingress_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r    <= data_nxt;
    bytes_r   <= bytes_nxt;
    last_r    <= last_nxt;
    route_r   <= route_nxt;
    ifc_r     <= ifc_nxt;
    sel_mem_r <= sel_mem_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wi[IW-1:0]] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[replay_index_r];
    end
  end

  assign out_valid = out_valid_r;
  always_comb begin
    out_beat.out_data      = sel_mem_r ? rd_data_r : data_r;
    out_beat.out_bytes     = bytes_r;
    out_beat.out_last      = last_r;
    out_beat.route         = route_r;
    out_beat.out_interface = ifc_r;
  end

  a_saved_xor_replay: assert property (@(posedge clk) disable iff (!rst_n)
    !(frame_saved_r && replay_pending_r))
    else $error("stored frame and pending replay at once");

  a_capture_saved: assert property (@(posedge clk) disable iff (!rst_n)
    (in_frame_r && frame_mode_r == MODE_CAPTURE) |-> frame_saved_r)
    else $error("capture in progress without stored frame");

  a_write_bound: assert property (@(posedge clk) disable iff (!rst_n)
    write_index_r <= DEPTH_C)
    else $error("write index past memory depth");

  a_pass_no_ifc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && route_r == ROUTE_PASS) |-> (ifc_r == '0 && !sel_mem_r))
    else $error("passed beat carries interface or replay data");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(data_r) && $stable(sel_mem_r)))
    else $error("output beat changed while stalled");

endmodule
`default_nettype wire

// ===== sim/frame_delay_reorder_tb.sv =====
`timescale 1ns / 100ps
module frame_delay_reorder_tb;
  import fdr_pkg::*;

  localparam int unsigned FRAME_BYTES = 1514;
  localparam int unsigned SAVE_DEPTH  = (FRAME_BYTES + 7) / 8;
  localparam int unsigned TAIL_BYTES  = FRAME_BYTES - 8 * (SAVE_DEPTH - 1);
  localparam int RANDOM_ITEMS = 700;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE       = 4;
  localparam int DRAIN        = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_PRINTS   = 50;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t           rk;
    fdr_in_t             beat;
    bit                  typed;
    bit                  has_res;
    fdr_out_t            res;
    logic [CIDX_W-1:0]   idx;
    logic [CFG_W-1:0]    val;
  } dir_row_t;

  typedef struct {
    logic [CIDX_W-1:0] idx;
    logic [CFG_W-1:0]  val;
  } reg_write_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  fdr_in_t           in_beat   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  fdr_out_t          out_beat;
  logic              cfg_we    = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  logic     beat_typed = 1'b0;
  logic     typed_has  = 1'b0;
  fdr_out_t typed_out  = '0;

  logic [63:0]      shadow_frame [SAVE_DEPTH];
  bit               shadow_saved    = 1'b0;
  logic [15:0]      shadow_count    = '0;
  fdr_mode_t        shadow_mode     = MODE_PASS;
  bit               shadow_in_frame = 1'b0;
  int               shadow_wr       = 0;
  bit               shadow_replay   = 1'b0;
  int               shadow_rd       = 0;
  logic [CFG_W-1:0] reg_delay       = '0;
  logic [CFG_W-1:0] reg_target      = '0;
  logic             reg_ingress     = 1'b0;

  fdr_out_t   pending_out [$];
  dir_row_t   dir_rows [$];
  reg_write_t reg_writes [$];

  int  cycle_count  = 0;
  int  err_count    = 0;
  int  useful_items = 0;
  int  beats_in     = 0;
  int  replay_beats = 0;
  int  results_seen = 0;
  int  captures     = 0;
  int  replays_done = 0;
  int  cfg_writes   = 0;
  bit  no_gaps      = 1'b0;
  bit  hold_armed   = 1'b0;
  bit  hold_done    = 1'b0;

  frame_delay_reorder #(.FRAME_BYTES(FRAME_BYTES)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_out.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (err_count < MAX_PRINTS)
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    err_count++;
  endtask

  function automatic bit route_beat(input fdr_in_t it, output fdr_out_t res);
    logic [63:0] mask;
    bit          fin;
    res = '0;
    if (it.kind == KIND_TICK) begin
      if (!shadow_replay) return 1'b0;
      fin = (shadow_rd + 1 >= SAVE_DEPTH);
      res.out_data      = (shadow_rd < shadow_wr) ? shadow_frame[shadow_rd] : '0;
      res.out_bytes     = fin ? BYTES_W'(TAIL_BYTES) : BYTES_W'(8);
      res.out_last      = fin;
      res.route         = reg_ingress ? ROUTE_INGRESS : ROUTE_EGRESS;
      res.out_interface = reg_target;
      if (fin) begin
        shadow_replay = 1'b0;
        shadow_rd = 0;
        replays_done++;
      end else begin
        shadow_rd++;
      end
      return 1'b1;
    end
    if (!shadow_in_frame) begin
      shadow_mode = MODE_PASS;
      if (!shadow_replay) begin
        if (shadow_count != 0 && !shadow_saved) begin
          if (it.frame_length == FRAME_BYTES) begin
            shadow_mode = MODE_CAPTURE;
            shadow_saved = 1'b1;
            shadow_count = shadow_count - 16'd1;
            shadow_wr = 0;
            captures++;
          end
        end else if (shadow_count != 0) begin
          shadow_count = shadow_count - 16'd1;
        end else if (shadow_saved) begin
          shadow_mode = MODE_REDIRECT;
        end
      end
    end
    shadow_in_frame = !it.beat_last;
    res.out_data  = it.beat_data;
    res.out_bytes = it.beat_bytes;
    res.out_last  = it.beat_last;
    case (shadow_mode)
      MODE_CAPTURE: begin
        if (shadow_wr < SAVE_DEPTH) begin
          mask = (it.beat_bytes >= 8) ? '1 : (64'd1 << (8 * it.beat_bytes)) - 64'd1;
          shadow_frame[shadow_wr] = it.beat_data & mask;
          shadow_wr++;
        end
        return 1'b0;
      end
      MODE_REDIRECT: begin
        res.route         = reg_ingress ? ROUTE_INGRESS : ROUTE_EGRESS;
        res.out_interface = reg_target;
        if (it.beat_last) begin
          shadow_saved = 1'b0;
          shadow_replay = 1'b1;
          shadow_rd = 0;
        end
        return 1'b1;
      end
      default: begin
        res.route         = ROUTE_PASS;
        res.out_interface = '0;
        return 1'b1;
      end
    endcase
  endfunction

  always @(posedge clk) begin : scoreboard
    fdr_out_t want;
    fdr_out_t predicted;
    bit       has;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_out.size() == 0) begin
          report_mismatch("beat with nothing pending", out_beat.out_data, '0);
        end else begin
          want = pending_out.pop_front();
          if (out_beat.out_data !== want.out_data)
            report_mismatch("out_data", out_beat.out_data, want.out_data);
          if (out_beat.out_bytes !== want.out_bytes)
            report_mismatch("out_bytes", out_beat.out_bytes, want.out_bytes);
          if (out_beat.out_last !== want.out_last)
            report_mismatch("out_last", out_beat.out_last, want.out_last);
          if (out_beat.route !== want.route)
            report_mismatch("route", out_beat.route, want.route);
          if (out_beat.out_interface !== want.out_interface)
            report_mismatch("out_interface", out_beat.out_interface, want.out_interface);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_DELAY: begin
            reg_delay = cfg_wdata;
            shadow_count = cfg_wdata;
          end
          CFG_TARGET:  reg_target = cfg_wdata;
          CFG_INGRESS: reg_ingress = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        has = route_beat(in_beat, predicted);
        if (in_beat.kind == KIND_BEAT) beats_in++;
        else if (has) replay_beats++;
        if (in_beat.kind == KIND_BEAT || has) useful_items++;
        if (beat_typed) begin
          if (typed_has) pending_out.push_back(typed_out);
        end else if (has) begin
          pending_out.push_back(predicted);
        end
      end
    end
  end

  initial begin : sink
    int r;
    int run;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_armed && !hold_done && in_valid) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          out_ready <= 1'b1;
          run = $urandom_range(100, 300);
        end else if (r < 55) begin
          out_ready <= 1'b1;
          run = $urandom_range(1, 24);
        end else if (r < 85) begin
          out_ready <= 1'b0;
          run = $urandom_range(1, 3);
        end else if (r < 97) begin
          out_ready <= 1'b0;
          run = $urandom_range(4, 12);
        end else begin
          out_ready <= 1'b0;
          run = $urandom_range(20, 60);
        end
        repeat (run) @(posedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic dir_row_t typed_row(input logic kind, input logic [63:0] d,
                                         input logic [3:0] b, input logic l,
                                         input logic [13:0] f, input bit has,
                                         input logic [63:0] od, input logic [3:0] ob,
                                         input logic ol, input logic [1:0] rt,
                                         input logic [15:0] ifc);
    dir_row_t row;
    row.rk = ROW_ITEM;
    row.beat.kind = kind;
    row.beat.beat_data = d;
    row.beat.beat_bytes = b;
    row.beat.beat_last = l;
    row.beat.frame_length = f;
    row.typed = 1'b1;
    row.has_res = has;
    row.res.out_data = od;
    row.res.out_bytes = ob;
    row.res.out_last = ol;
    row.res.route = rt;
    row.res.out_interface = ifc;
    row.idx = '0;
    row.val = '0;
    return row;
  endfunction

  function automatic dir_row_t item_row(input logic kind, input logic [63:0] d,
                                        input logic [3:0] b, input logic l,
                                        input logic [13:0] f);
    dir_row_t row;
    row = typed_row(kind, d, b, l, f, 1'b0, '0, '0, 1'b0, ROUTE_PASS, '0);
    row.typed = 1'b0;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CIDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] val);
    dir_row_t row;
    row = item_row(KIND_BEAT, '0, '0, 1'b0, '0);
    row.rk = ROW_CFG;
    row.idx = idx;
    row.val = val;
    return row;
  endfunction

  function automatic fdr_in_t rand_tick();
    fdr_in_t it;
    it.kind = KIND_TICK;
    it.beat_data = {$urandom, $urandom};
    it.beat_bytes = BYTES_W'($urandom_range(0, 15));
    it.beat_last = 1'($urandom_range(0, 1));
    it.frame_length = LEN_W'($urandom_range(0, 16383));
    return it;
  endfunction

  task automatic send_item(input fdr_in_t it, input bit typed, input bit has,
                           input fdr_out_t res);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_beat    <= it;
    beat_typed <= typed;
    typed_has  <= has;
    typed_out  <= res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_frame(input logic [LEN_W-1:0] flen, input int nbeats, input bit close);
    fdr_in_t it;
    for (int i = 0; i < nbeats; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(rand_tick(), 1'b0, 1'b0, '0);
      it.kind = KIND_BEAT;
      it.beat_data = {$urandom, $urandom};
      it.beat_bytes = ($urandom_range(0, 7) == 0) ? BYTES_W'($urandom_range(0, 15))
                                                 : BYTES_W'($urandom_range(1, 8));
      it.beat_last = close && (i == nbeats - 1);
      it.frame_length = (i == 0) ? flen : LEN_W'($urandom_range(0, 16383));
      send_item(it, 1'b0, 1'b0, '0);
    end
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs();
    foreach (reg_writes[i]) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_writes[i].idx;
      cfg_wdata <= reg_writes[i].val;
      @(posedge clk);
      cfg_writes++;
    end
    cfg_we <= 1'b0;
    reg_writes.delete();
  endtask

  initial begin : stimulus
    int               dir_useful;
    int               nframes;
    int               nbeats;
    int               nticks;
    int               r;
    logic [LEN_W-1:0] flen;
    logic [CFG_W-1:0] val;

    dir_rows.push_back(typed_row(KIND_BEAT, '1, 4'd8, 1'b1, 14'd0,
                                 1'b1, '1, 4'd8, 1'b1, ROUTE_PASS, 16'd0));
    dir_rows.push_back(typed_row(KIND_BEAT, '0, 4'd1, 1'b1, 14'd16383,
                                 1'b1, '0, 4'd1, 1'b1, ROUTE_PASS, 16'd0));
    dir_rows.push_back(typed_row(KIND_TICK, 64'h0123_4567_89AB_CDEF, 4'd15, 1'b1, 14'd1514,
                                 1'b0, '0, '0, 1'b0, ROUTE_PASS, 16'd0));
    dir_rows.push_back(cfg_row(CFG_TARGET, 16'hFFFF));
    dir_rows.push_back(cfg_row(CFG_INGRESS, 16'd1));
    dir_rows.push_back(cfg_row(CFG_DELAY, 16'd2));
    // wrong length while armed: pass, not counted
    dir_rows.push_back(item_row(KIND_BEAT, 64'hA5A5_5A5A_F00F_0FF0, 4'd5, 1'b1,
                                LEN_W'(FRAME_BYTES - 1)));
    // short capture with a tick inside the frame
    dir_rows.push_back(typed_row(KIND_BEAT, 64'h1122_3344_5566_7788, 4'd8, 1'b0,
                                 LEN_W'(FRAME_BYTES), 1'b0, '0, '0, 1'b0, ROUTE_PASS, 16'd0));
    dir_rows.push_back(typed_row(KIND_TICK, '1, 4'd8, 1'b0, 14'd0,
                                 1'b0, '0, '0, 1'b0, ROUTE_PASS, 16'd0));
    dir_rows.push_back(typed_row(KIND_BEAT, '1, 4'd3, 1'b0, 14'd0,
                                 1'b0, '0, '0, 1'b0, ROUTE_PASS, 16'd0));
    dir_rows.push_back(typed_row(KIND_BEAT, 64'hDEAD_BEEF_CAFE_F00D, 4'd15, 1'b0, 14'd16383,
                                 1'b0, '0, '0, 1'b0, ROUTE_PASS, 16'd0));
    dir_rows.push_back(typed_row(KIND_BEAT, '1, 4'd0, 1'b1, 14'd0,
                                 1'b0, '0, '0, 1'b0, ROUTE_PASS, 16'd0));
    dir_rows.push_back(item_row(KIND_BEAT, 64'h0F0E_0D0C_0B0A_0908, 4'd8, 1'b1,
                                LEN_W'(FRAME_BYTES)));
    dir_rows.push_back(item_row(KIND_BEAT, 64'h8877_6655_4433_2211, 4'd8, 1'b0, 14'd64));
    dir_rows.push_back(item_row(KIND_BEAT, 64'h0000_0000_C0DE_BABE, 4'd4, 1'b1, 14'd0));
    dir_rows.push_back(item_row(KIND_TICK, '0, 4'd0, 1'b0, 14'd0));
    dir_rows.push_back(item_row(KIND_TICK, '1, 4'd15, 1'b1, 14'd16383));
    // frame during a replay: passes uncounted
    dir_rows.push_back(item_row(KIND_BEAT, 64'h5555_AAAA_5555_AAAA, 4'd8, 1'b1, 14'd20));
    dir_rows.push_back(item_row(KIND_TICK, '0, 4'd0, 1'b0, 14'd0));
    dir_rows.push_back(item_row(KIND_TICK, '0, 4'd0, 1'b0, 14'd0));
    dir_rows.push_back(item_row(KIND_TICK, '0, 4'd0, 1'b0, 14'd0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].rk == ROW_CFG) begin
        reg_writes.push_back('{idx: dir_rows[i].idx, val: dir_rows[i].val});
      end else begin
        if (reg_writes.size() != 0) begin
          settle_block();
          write_regs();
        end
        send_item(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].has_res, dir_rows[i].res);
      end
    end
    settle_block();
    dir_useful = useful_items;
    hold_armed = 1'b1;

    while (useful_items - dir_useful < RANDOM_ITEMS) begin
      settle_block();
      if ($urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, 9);
        if (r == 0) val = 16'd0;
        else if (r == 1) val = 16'hFFFF;
        else if (r == 2) val = CFG_W'($urandom);
        else val = CFG_W'($urandom_range(1, 4));
        reg_writes.push_back('{idx: CFG_DELAY, val: val});
      end
      if ($urandom_range(0, 1) != 0) begin
        r = $urandom_range(0, 3);
        if (r == 0) val = 16'd0;
        else if (r == 1) val = 16'hFFFF;
        else val = CFG_W'($urandom);
        reg_writes.push_back('{idx: CFG_TARGET, val: val});
      end
      if ($urandom_range(0, 1) != 0)
        reg_writes.push_back('{idx: CFG_INGRESS, val: CFG_W'($urandom_range(0, 1))});
      write_regs();

      no_gaps = ($urandom_range(0, 4) == 0);
      nframes = $urandom_range(2, 7);
      for (int f = 0; f < nframes; f++) begin
        r = $urandom_range(0, 9);
        if (r < 4) begin
          flen = LEN_W'(FRAME_BYTES);
        end else if (r == 4) begin
          case ($urandom_range(0, 3))
            0: flen = '0;
            1: flen = '1;
            2: flen = LEN_W'(FRAME_BYTES - 1);
            default: flen = LEN_W'(FRAME_BYTES + 1);
          endcase
        end else begin
          flen = LEN_W'($urandom_range(0, 16383));
        end
        if (flen == FRAME_BYTES && $urandom_range(0, 11) == 0)
          nbeats = $urandom_range(SAVE_DEPTH - 2, SAVE_DEPTH + 3);
        else if ($urandom_range(0, 19) == 0)
          nbeats = $urandom_range(5, 12);
        else
          nbeats = $urandom_range(1, 4);
        send_frame(flen, nbeats, $urandom_range(0, 15) != 0);
      end

      settle_block();
      if (shadow_replay) begin
        if ($urandom_range(0, 3) != 0) nticks = SAVE_DEPTH - shadow_rd;
        else nticks = $urandom_range(1, 12);
      end else begin
        nticks = $urandom_range(0, 2);
      end
      for (int t = 0; t < nticks; t++) begin
        if ($urandom_range(0, 15) == 0)
          send_frame(LEN_W'($urandom_range(0, 16383)), 1, 1'b1);
        send_item(rand_tick(), 1'b0, 1'b0, '0);
      end
    end

    settle_block();
    repeat (DRAIN) @(posedge clk);
    if (pending_out.size() != 0)
      report_mismatch("results never delivered", 64'(pending_out.size()), '0);

    $display("run covered %0d frame beats, %0d replay beats, %0d results checked",
             beats_in, replay_beats, results_seen);
    $display("%0d captures, %0d full replays, %0d register writes, %0d mismatches",
             captures, replays_done, cfg_writes, err_count);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
